FILE: hw/rtl/ppc_pkg.sv
package ppc_pkg;

    localparam int CoordW = 32;
    localparam int NormW  = 16;
    localparam int EpsW   = 12;
    localparam int SideW  = 40;
    localparam int TW     = 17;
    localparam int NumW   = SideW + 16;
    localparam int RegIdxW = 3;

    // Register indexes of the configuration port.
    localparam logic [RegIdxW-1:0] RegNormalX  = 3'd0;
    localparam logic [RegIdxW-1:0] RegNormalY  = 3'd1;
    localparam logic [RegIdxW-1:0] RegNormalZ  = 3'd2;
    localparam logic [RegIdxW-1:0] RegDistance = 3'd3;
    localparam logic [RegIdxW-1:0] RegEpsilon  = 3'd4;

    // Sources of the edge start and end vertex operands.
    localparam logic [1:0] SelCur   = 2'd0;
    localparam logic [1:0] SelPrev  = 2'd1;
    localparam logic [1:0] SelFirst = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_cur;     // capture input vertex, clear accumulator
        logic       dot_en;       // accumulate one product of the dot product
        logic [1:0] axis;         // coordinate in use
        logic       side_done;    // finish side value of the current vertex
        logic       edge_start;   // latch edge operands (P, Q)
        logic [1:0] p_sel;        // edge start vertex
        logic [1:0] q_sel;        // edge end vertex
        logic       div_start;    // start the t divider
        logic       div_step;     // one restoring division step
        logic       div_fix;      // clamp t to 1.0 and latch it
        logic       mul_en;       // multiply one coordinate delta by t
        logic       lerp_en;      // add P and saturate one coordinate
        logic       out_p;        // load result register with P
        logic       out_i;        // load result register with intersection
        logic       out_marker;   // load result register with the empty marker
        logic       out_last;     // end_of_polygon for the loaded result
        logic       commit;       // shift current vertex into prev/first
        logic       make_first;   // also store the current vertex as first
    } ppc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic p_inside;    // side(P) >= -epsilon
        logic crossing;    // sign of (side > 0) differs between P and Q
        logic final_flag;  // current vertex closes the polygon
        logic close_emits; // closing edge (current to first) yields a result
    } ppc_sts_t;

endpackage

FILE: hw/rtl/ppc_datapath.sv
module ppc_datapath (
    input  logic                                aclk,
    input  ppc_pkg::ppc_cmd_t                   cmd,
    output ppc_pkg::ppc_sts_t                   sts,
    input  logic [ppc_pkg::CoordW-1:0]          in_x,
    input  logic [ppc_pkg::CoordW-1:0]          in_y,
    input  logic [ppc_pkg::CoordW-1:0]          in_z,
    input  logic                                in_final,
    input  logic signed [ppc_pkg::NormW-1:0]    normal_x,
    input  logic signed [ppc_pkg::NormW-1:0]    normal_y,
    input  logic signed [ppc_pkg::NormW-1:0]    normal_z,
    input  logic signed [ppc_pkg::CoordW-1:0]   plane_distance,
    input  logic [ppc_pkg::EpsW-1:0]            inside_epsilon,
    output logic [ppc_pkg::CoordW-1:0]          res_x,
    output logic [ppc_pkg::CoordW-1:0]          res_y,
    output logic [ppc_pkg::CoordW-1:0]          res_z,
    output logic                                res_has,
    output logic                                res_last
);
    localparam int CW = ppc_pkg::CoordW;
    localparam int SW = ppc_pkg::SideW;
    localparam int NW = ppc_pkg::NumW;
    localparam int TW = ppc_pkg::TW;
    localparam int AccW = 52;
    localparam int ProdW = CW + 1 + TW + 1;

    logic signed [CW-1:0] cur_reg [3];
    logic signed [CW-1:0] prev_reg [3];
    logic signed [CW-1:0] first_reg [3];
    logic signed [CW-1:0] p_reg [3];
    logic signed [CW-1:0] q_reg [3];
    logic signed [CW-1:0] ix_reg [3];
    logic signed [SW-1:0] cur_side_reg, prev_side_reg, first_side_reg;
    logic signed [SW-1:0] sp_reg, sq_reg;
    logic signed [AccW-1:0] acc_reg;
    logic                 final_reg;
    logic [NW-1:0]        rem_reg;
    logic [NW-1:0]        quo_reg;
    logic [NW-1:0]        num_reg;
    logic [SW-1:0]        den_reg;
    logic [TW-1:0]        t_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic [1:0]           prod_axis_reg;

    logic signed [CW-1:0]   mul_coord;
    logic signed [ppc_pkg::NormW-1:0] mul_norm;
    logic signed [AccW-1:0] side_full;
    logic signed [SW-1:0]   side_val;
    logic signed [CW-1:0]   p_sel_v [3];
    logic signed [CW-1:0]   q_sel_v [3];
    logic signed [SW-1:0]   sp_sel, sq_sel;
    logic [SW-1:0]          an, ad;
    logic signed [SW:0]     den_s;
    logic [NW:0]            rem_try;
    logic [NW-1:0]          t_round;
    logic signed [CW:0]     delta;
    logic signed [ProdW-1:0] prod_r;
    logic signed [CW+1:0]   lerp;
    logic signed [CW-1:0]   lerp_sat;
    logic signed [SW-1:0]   neg_eps;

    // Select the normal component and coordinate for one dot product step.
    always_comb begin
        case (cmd.axis)
            2'd0: begin
                mul_coord = cur_reg[0];
                mul_norm  = normal_x;
            end
            2'd1: begin
                mul_coord = cur_reg[1];
                mul_norm  = normal_y;
            end
            default: begin
                mul_coord = cur_reg[2];
                mul_norm  = normal_z;
            end
        endcase
    end

    // Side value: round the Q.26 sum to Q28.12, then subtract the distance.
    assign side_full = (acc_reg + AccW'(8192)) >>> 14;
    assign side_val  = SW'(side_full) - SW'(plane_distance);

    // Edge operand selection.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (cmd.p_sel)
                ppc_pkg::SelPrev: p_sel_v[i] = prev_reg[i];
                default:          p_sel_v[i] = cur_reg[i];
            endcase
            case (cmd.q_sel)
                ppc_pkg::SelFirst: q_sel_v[i] = first_reg[i];
                default:           q_sel_v[i] = cur_reg[i];
            endcase
        end
        case (cmd.p_sel)
            ppc_pkg::SelPrev: sp_sel = prev_side_reg;
            default:          sp_sel = cur_side_reg;
        endcase
        case (cmd.q_sel)
            ppc_pkg::SelFirst: sq_sel = first_side_reg;
            default:           sq_sel = cur_side_reg;
        endcase
    end

    // Magnitudes for the division t = |sP| / |sP - sQ|.
    assign den_s  = SW'(sp_reg) - (SW+1)'(sq_reg);
    assign an     = sp_reg[SW-1] ? SW'(-sp_reg) : SW'(sp_reg);
    assign ad     = den_s[SW] ? SW'(-den_s) : SW'(den_s);
    assign rem_try = {rem_reg, num_reg[NW-1]} - (NW+1)'(den_reg);
    assign t_round = (quo_reg > NW'(65536)) ? NW'(65536) : quo_reg;

    // Interpolation for one coordinate at a time.
    assign delta    = (CW+1)'(q_reg[cmd.axis]) - (CW+1)'(p_reg[cmd.axis]);
    assign prod_r   = (prod_reg + ProdW'(32768)) >>> 16;
    assign lerp     = (CW+2)'(p_reg[prod_axis_reg]) + (CW+2)'(prod_r);
    assign lerp_sat = (lerp > (CW+2)'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                      (lerp < -(CW+2)'(33'sh0_8000_0000)) ? 32'sh8000_0000 :
                      CW'(lerp);

    // Keep test against the signed tolerance.
    assign neg_eps = -$signed(SW'(inside_epsilon));

    assign sts.p_inside    = sp_reg >= neg_eps;
    assign sts.crossing    = (sp_reg > 0) != (sq_reg > 0);
    assign sts.final_flag  = final_reg;
    assign sts.close_emits = (cur_side_reg >= neg_eps) ||
                             ((cur_side_reg > 0) != (first_side_reg > 0));

    always_ff @(posedge aclk) begin
        // Vertex capture and dot product.
        if (cmd.load_cur) begin
            cur_reg[0] <= in_x;
            cur_reg[1] <= in_y;
            cur_reg[2] <= in_z;
            final_reg  <= in_final;
            acc_reg    <= '0;
        end else if (cmd.dot_en) begin
            acc_reg <= acc_reg + AccW'(mul_coord * mul_norm);
        end
        if (cmd.side_done) cur_side_reg <= side_val;
        // Edge operands.
        if (cmd.edge_start) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= p_sel_v[i];
                q_reg[i] <= q_sel_v[i];
            end
            sp_reg <= sp_sel;
            sq_reg <= sq_sel;
        end
        // Restoring divider, one quotient bit per cycle; half the divisor is
        // added to the numerator so that the quotient rounds half up.
        if (cmd.div_start) begin
            num_reg <= (NW'(an) << 16) + NW'(ad[SW-1:1]);
            den_reg <= ad;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            if (!rem_try[NW]) begin
                rem_reg <= rem_try[NW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[NW-2:0], num_reg[NW-1]};
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
        if (cmd.div_fix) t_reg <= TW'(t_round);
        // One coordinate multiply at a time, registered before the add.
        if (cmd.mul_en) begin
            prod_reg      <= ProdW'(delta * $signed({1'b0, t_reg}));
            prod_axis_reg <= cmd.axis;
        end
        if (cmd.lerp_en) ix_reg[prod_axis_reg] <= lerp_sat;
        // Result register.
        if (cmd.out_p) begin
            res_x   <= p_reg[0];
            res_y   <= p_reg[1];
            res_z   <= p_reg[2];
            res_has <= 1'b1;
            res_last <= cmd.out_last;
        end else if (cmd.out_i) begin
            res_x   <= ix_reg[0];
            res_y   <= ix_reg[1];
            res_z   <= ix_reg[2];
            res_has <= 1'b1;
            res_last <= cmd.out_last;
        end else if (cmd.out_marker) begin
            res_x   <= '0;
            res_y   <= '0;
            res_z   <= '0;
            res_has <= 1'b0;
            res_last <= 1'b1;
        end
        // Polygon state update after the item is done.
        if (cmd.commit) begin
            for (int i = 0; i < 3; i++) prev_reg[i] <= cur_reg[i];
            prev_side_reg <= cur_side_reg;
            if (cmd.make_first) begin
                for (int i = 0; i < 3; i++) first_reg[i] <= cur_reg[i];
                first_side_reg <= cur_side_reg;
            end
        end
    end

endmodule

FILE: hw/rtl/ppc_controller.sv
module ppc_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ppc_pkg::ppc_cmd_t cmd,
    input  ppc_pkg::ppc_sts_t sts
);
    localparam int StW = 4;
    localparam logic [StW-1:0] StIdle   = 4'd0;
    localparam logic [StW-1:0] StDot    = 4'd1;
    localparam logic [StW-1:0] StSide   = 4'd2;
    localparam logic [StW-1:0] StEdge   = 4'd3;
    localparam logic [StW-1:0] StTest   = 4'd4;
    localparam logic [StW-1:0] StDiv    = 4'd5;
    localparam logic [StW-1:0] StFix    = 4'd6;
    localparam logic [StW-1:0] StMul    = 4'd7;
    localparam logic [StW-1:0] StLerp   = 4'd8;
    localparam logic [StW-1:0] StEmitI  = 4'd9;
    localparam logic [StW-1:0] StNext   = 4'd10;
    localparam logic [StW-1:0] StWait   = 4'd11;
    localparam int DivSteps = ppc_pkg::NumW;
    localparam int CntW = $clog2(DivSteps + 1);

    logic [StW-1:0]  state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [1:0]      edge_reg, edge_next;      // 0 prev->cur, 1 cur->first, 2 self
    logic            seen_reg, seen_next;
    logic            any_reg, any_next;        // a result emitted for this item
    logic            ov_reg, ov_next;          // output register full
    logic            p_done_reg, p_done_next;  // P test handled for this edge
    logic            last_edge;

    assign s_ready = (state_reg == StIdle);
    assign m_valid = ov_reg;
    // No result of this item can follow the current edge.
    assign last_edge = sts.final_flag && (edge_reg != 2'd0 || !sts.close_emits);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        edge_next   = edge_reg;
        seen_next   = seen_reg;
        any_next    = any_reg;
        p_done_next = p_done_reg;
        ov_next     = ov_reg && !m_ready;
        cmd         = '0;
        case (state_reg)
            StIdle: begin
                if (s_valid) begin
                    cmd.load_cur = 1'b1;
                    cnt_next     = '0;
                    any_next     = 1'b0;
                    state_next   = StDot;
                end
            end
            StDot: begin
                cmd.dot_en = 1'b1;
                cmd.axis   = cnt_reg[1:0];
                cnt_next   = cnt_reg + CntW'(1);
                if (cnt_reg == CntW'(2)) state_next = StSide;
            end
            StSide: begin
                cmd.side_done = 1'b1;
                if (!seen_reg) begin
                    if (sts.final_flag) begin
                        edge_next  = 2'd2;
                        state_next = StEdge;
                    end else begin
                        state_next = StNext;
                    end
                end else begin
                    edge_next  = 2'd0;
                    state_next = StEdge;
                end
            end
            StEdge: begin
                cmd.edge_start = 1'b1;
                case (edge_reg)
                    2'd0: begin
                        cmd.p_sel = ppc_pkg::SelPrev;
                        cmd.q_sel = ppc_pkg::SelCur;
                    end
                    2'd1: begin
                        cmd.p_sel = ppc_pkg::SelCur;
                        cmd.q_sel = ppc_pkg::SelFirst;
                    end
                    default: begin
                        cmd.p_sel = ppc_pkg::SelCur;
                        cmd.q_sel = ppc_pkg::SelCur;
                    end
                endcase
                p_done_next = 1'b0;
                state_next  = StTest;
            end
            StTest: begin
                if (!p_done_reg && sts.p_inside) begin
                    if (!ov_next) begin
                        cmd.out_p   = 1'b1;
                        cmd.out_last = last_edge && !sts.crossing;
                        ov_next     = 1'b1;
                        any_next    = 1'b1;
                        p_done_next = 1'b1;
                    end
                end else if (sts.crossing) begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = StDiv;
                end else begin
                    state_next = StNext;
                end
            end
            StDiv: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CntW'(1);
                if (cnt_reg == CntW'(DivSteps - 1)) state_next = StFix;
            end
            StFix: begin
                cmd.div_fix = 1'b1;
                cnt_next    = '0;
                state_next  = StMul;
            end
            StMul: begin
                cmd.mul_en = 1'b1;
                cmd.axis   = cnt_reg[1:0];
                state_next = StLerp;
            end
            StLerp: begin
                cmd.lerp_en = 1'b1;
                cnt_next    = cnt_reg + CntW'(1);
                state_next  = (cnt_reg == CntW'(2)) ? StEmitI : StMul;
            end
            StEmitI: begin
                if (!ov_next) begin
                    cmd.out_i    = 1'b1;
                    cmd.out_last = last_edge;
                    ov_next      = 1'b1;
                    any_next     = 1'b1;
                    state_next   = StNext;
                end
            end
            StNext: begin
                if (sts.final_flag && edge_reg == 2'd0 && seen_reg) begin
                    edge_next  = 2'd1;
                    state_next = StEdge;
                end else if (sts.final_flag && !any_reg) begin
                    if (!ov_next) begin
                        cmd.out_marker = 1'b1;
                        ov_next        = 1'b1;
                        state_next     = StWait;
                    end
                end else begin
                    state_next = StWait;
                end
            end
            StWait: begin
                cmd.commit     = 1'b1;
                cmd.make_first = !seen_reg;
                seen_next      = !sts.final_flag;
                state_next     = StIdle;
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= StIdle;
            cnt_reg    <= '0;
            edge_reg   <= '0;
            seen_reg   <= 1'b0;
            any_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            p_done_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            edge_reg   <= edge_next;
            seen_reg   <= seen_next;
            any_reg    <= any_next;
            ov_reg     <= ov_next;
            p_done_reg <= p_done_next;
        end
    end

endmodule

FILE: hw/rtl/polygon_plane_clipper_unit.sv
// One-plane polygon clipper. Vertices arrive one per transaction on the s_
// channel with tlast closing the polygon; clipped vertices leave on the m_
// channel, the last result of a closing vertex with tlast set. A closing
// vertex that yields no vertex gives one transaction with tuser low. Each
// vertex is accepted, gets one multiply-accumulate per coordinate and
// has its side value finished; then per edge the operands are latched and
// tested, a kept start vertex is emitted and, if the edge crosses the
// plane, the bit-serial t divider runs, t is clamped, three shared
// coordinate multiplies and adds run and the intersection is loaded; the
// vertex is then committed. A closing vertex also takes the closing edge (a
// lone one only that), may add the empty marker; a full result register stalls.
module polygon_plane_clipper_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // vert_x, vert_y, vert_z
    input  logic         s_tlast,   // final_vertex
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // out_x, out_y, out_z
    output logic         m_tlast,   // end_of_polygon
    output logic         m_tuser,   // has_vertex
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    ppc_pkg::ppc_cmd_t cmd;
    ppc_pkg::ppc_sts_t sts;

    logic signed [15:0] normal_x_reg, normal_y_reg, normal_z_reg;
    logic signed [31:0] distance_reg;
    logic [11:0]        epsilon_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_x_reg <= '0;
            normal_y_reg <= '0;
            normal_z_reg <= 16'sd16384;
            distance_reg <= '0;
            epsilon_reg  <= 12'd4;
        end else if (cfg_we) begin
            case (cfg_index)
                ppc_pkg::RegNormalX:  normal_x_reg <= cfg_wdata[15:0];
                ppc_pkg::RegNormalY:  normal_y_reg <= cfg_wdata[15:0];
                ppc_pkg::RegNormalZ:  normal_z_reg <= cfg_wdata[15:0];
                ppc_pkg::RegDistance: distance_reg <= cfg_wdata;
                ppc_pkg::RegEpsilon:  epsilon_reg  <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    ppc_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    ppc_datapath u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .sts            (sts),
        .in_x           (s_tdata[31:0]),
        .in_y           (s_tdata[63:32]),
        .in_z           (s_tdata[95:64]),
        .in_final       (s_tlast),
        .normal_x       (normal_x_reg),
        .normal_y       (normal_y_reg),
        .normal_z       (normal_z_reg),
        .plane_distance (distance_reg),
        .inside_epsilon (epsilon_reg),
        .res_x          (m_tdata[31:0]),
        .res_y          (m_tdata[63:32]),
        .res_z          (m_tdata[95:64]),
        .res_has        (m_tuser),
        .res_last       (m_tlast)
    );

endmodule
